// ===== src/ascii_to_u32_parser_defines.svh =====
// Assertion macros shared by the ASCII to u32 parser RTL.
`ifndef ASCII_TO_U32_PARSER_DEFINES_SVH
`define ASCII_TO_U32_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define A2U_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define A2U_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/a2u_pkg.sv =====
// Types, codes and constants shared by the ASCII to u32 parser modules.
package a2u_pkg;

   typedef enum logic [5:0] {
      PH_START = 6'b000001,
      PH_ZERO  = 6'b000010,
      PH_DEC   = 6'b000100,
      PH_HEX   = 6'b001000,
      PH_OCT   = 6'b010000,
      PH_ERR   = 6'b100000
   } phase_type;

   typedef struct packed {
      logic       is_nul;
      logic       is_zero;
      logic       is_x;
      logic       is_dec;
      logic       is_hex;
      logic       below_six;
      logic [3:0] digit;
   } char_class_type;

   localparam logic [7:0]  CHAR_NUL   = 8'h00;
   localparam logic [7:0]  CHAR_ZERO  = 8'h30;
   localparam logic [7:0]  CHAR_SIX   = 8'h36;
   localparam logic [7:0]  CHAR_NINE  = 8'h39;
   localparam logic [7:0]  CHAR_UP_A  = 8'h41;
   localparam logic [7:0]  CHAR_UP_F  = 8'h46;
   localparam logic [7:0]  CHAR_UP_X  = 8'h58;
   localparam logic [7:0]  CHAR_LO_A  = 8'h61;
   localparam logic [7:0]  CHAR_LO_F  = 8'h66;
   localparam logic [7:0]  CHAR_LO_X  = 8'h78;
   localparam logic [3:0]  HEX_LETTER_OFFSET = 4'd9;
   localparam logic [31:0] DEC_LIMIT  = 32'd429496729;

endpackage

// ===== src/a2u_char_class.sv =====
// Character classifier: sorts one ASCII code into digit classes and its digit value.
module a2u_char_class (
   input  logic [7:0]              char_code,
   output a2u_pkg::char_class_type char_class
);

   logic is_dec;
   logic is_letter;

   assign is_dec    = (char_code >= a2u_pkg::CHAR_ZERO) && (char_code <= a2u_pkg::CHAR_NINE);
   assign is_letter = ((char_code >= a2u_pkg::CHAR_UP_A) && (char_code <= a2u_pkg::CHAR_UP_F)) ||
                      ((char_code >= a2u_pkg::CHAR_LO_A) && (char_code <= a2u_pkg::CHAR_LO_F));

   always_comb begin
      char_class.is_nul    = (char_code == a2u_pkg::CHAR_NUL);
      char_class.is_zero   = (char_code == a2u_pkg::CHAR_ZERO);
      char_class.is_x      = (char_code == a2u_pkg::CHAR_UP_X) ||
                             (char_code == a2u_pkg::CHAR_LO_X);
      char_class.is_dec    = is_dec;
      char_class.is_hex    = is_dec || is_letter;
      char_class.below_six = (char_code < a2u_pkg::CHAR_SIX);
      // Upper and lower case letters share the low nibble, 1 for A through 6 for F.
      char_class.digit     = is_letter ? (char_code[3:0] + a2u_pkg::HEX_LETTER_OFFSET)
                                       : char_code[3:0];
   end

endmodule

// ===== src/a2u_core.sv =====
// Parse state and accumulator, advanced by one classified character per step.
module a2u_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  a2u_pkg::char_class_type char_class,
   input  logic                    auto_base,
   output a2u_pkg::phase_type      phase,
   output logic [31:0]             result_value,
   output logic                    result_error
);

   a2u_pkg::phase_type phase_ff, phase_in;
   logic [31:0]        acc_ff, acc_in;
   logic               dec_ok;
   logic               hex_ok;
   logic [31:0]        dec_next;
   logic [31:0]        hex_next;

   assign dec_ok = char_class.is_dec &&
                   ((acc_ff < a2u_pkg::DEC_LIMIT) ||
                    ((acc_ff == a2u_pkg::DEC_LIMIT) && char_class.below_six));
   // Times ten as eight plus two, then the digit.
   assign dec_next = {acc_ff[28:0], 3'b000} + {acc_ff[30:0], 1'b0} +
                     {28'd0, char_class.digit};
   assign hex_ok   = char_class.is_hex && (acc_ff[31:28] == 4'd0);
   assign hex_next = {acc_ff[27:0], char_class.digit};

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      if (step) begin
         if (char_class.is_nul) begin
            phase_in = a2u_pkg::PH_START;
            acc_in   = 32'd0;
         end else begin
            case (phase_ff)
               a2u_pkg::PH_START: begin
                  acc_in = 32'd0;
                  if (auto_base && char_class.is_zero) begin
                     phase_in = a2u_pkg::PH_ZERO;
                  end else if (char_class.is_dec) begin
                     phase_in = a2u_pkg::PH_DEC;
                     acc_in   = {28'd0, char_class.digit};
                  end else begin
                     phase_in = a2u_pkg::PH_ERR;
                  end
               end
               a2u_pkg::PH_ZERO: begin
                  phase_in = char_class.is_x ? a2u_pkg::PH_HEX : a2u_pkg::PH_OCT;
               end
               a2u_pkg::PH_DEC: begin
                  if (dec_ok) begin
                     acc_in = dec_next;
                  end else begin
                     phase_in = a2u_pkg::PH_ERR;
                  end
               end
               a2u_pkg::PH_HEX: begin
                  if (hex_ok) begin
                     acc_in = hex_next;
                  end else begin
                     phase_in = a2u_pkg::PH_ERR;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= a2u_pkg::PH_START;
         acc_ff   <= 32'd0;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
      end
   end

   assign phase        = phase_ff;
   assign result_error = (phase_ff == a2u_pkg::PH_ZERO) || (phase_ff == a2u_pkg::PH_OCT) ||
                         (phase_ff == a2u_pkg::PH_ERR);
   assign result_value = ((phase_ff == a2u_pkg::PH_ZERO) || (phase_ff == a2u_pkg::PH_OCT))
                         ? 32'd0 : acc_ff;

endmodule

// ===== src/ascii_to_u32_parser.sv =====
// Top level of the ASCII string to unsigned 32-bit parser.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  req_char_code[7:0]
//   rsp_     out        rsp_valid/rsp_stall  rsp_value[31:0], rsp_error
//   csr_     in         csr_valid/csr_ready  csr_auto_base
//
// One character per cycle is taken unless a NUL waits on a stalled result; the
// accumulator update (times ten or shift by four, plus a digit) sits between
// the input register and the parse state, and a NUL's result is registered.
// Reset is synchronous: empty pipeline, start of string, auto base on.
// A stalled result blocks only NUL characters; other characters keep flowing.
`include "ascii_to_u32_parser_defines.svh"

module ascii_to_u32_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_value,
   output logic        rsp_error,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_auto_base
);

   logic                    in_valid_ff, in_valid_in;
   logic [7:0]              in_char_ff;
   logic                    auto_base_ff, auto_base_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [31:0]             rsp_value_ff;
   logic                    rsp_error_ff;
   a2u_pkg::char_class_type char_class;
   a2u_pkg::phase_type      phase;
   logic [31:0]             result_value;
   logic                    result_error;
   logic                    out_free;
   logic                    consume;
   logic                    load_out;
   logic                    req_take;

   a2u_char_class u_char_class (
      .char_code  (in_char_ff),
      .char_class (char_class)
   );

   a2u_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (consume),
      .char_class   (char_class),
      .auto_base    (auto_base_ff),
      .phase        (phase),
      .result_value (result_value),
      .result_error (result_error)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign consume   = in_valid_ff && (!char_class.is_nul || out_free);
   assign load_out  = consume && char_class.is_nul;
   assign req_stall = in_valid_ff && !consume;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take ? 1'b1 : (consume ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = load_out ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   assign auto_base_in = (csr_valid && csr_ready) ? csr_auto_base : auto_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         auto_base_ff <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         auto_base_ff <= auto_base_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_char_code;
      end
      if (load_out) begin
         rsp_value_ff <= result_value;
         rsp_error_ff <= result_error;
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_error = rsp_error_ff;

   `A2U_ASSERT_NEXT(a_req_lands, clock, reset, req_take, in_valid_ff,
      "accepted request did not reach the input register")
   `A2U_ASSERT_NEXT(a_held_request, clock, reset, in_valid_ff && !consume, in_valid_ff,
      "waiting request was dropped from the input register")
   `A2U_ASSERT_NEXT(a_nul_restarts, clock, reset, load_out, phase == a2u_pkg::PH_START,
      "parse state did not return to start after a terminator")
   `A2U_ASSERT_NEXT(a_octal_error, clock, reset,
      load_out && (phase == a2u_pkg::PH_ZERO || phase == a2u_pkg::PH_OCT),
      rsp_valid && rsp_error && (rsp_value == 32'd0),
      "octal string did not give an error with value zero")

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the ASCII string to unsigned 32-bit parser.
module testbench;

   localparam int          CYCLE_LIMIT = 300000;
   localparam int          DRAIN_CYCLES = 4;
   localparam int          MAX_REPORTS = 10;
   localparam int          MAX_GAP = 40;
   localparam logic [31:0] HEX_LIMIT = 32'h1000_0000;
   localparam logic [7:0]  CHAR_LO_Z = 8'h7A;
   localparam logic [7:0]  CASE_OFFSET = 8'h20;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic [31:0] value;
      logic        error;
   } parse_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_code = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_value;
   logic        rsp_error;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_auto_base = 1'b1;

   // Predictor state, kept in step with every accepted request.
   a2u_pkg::phase_type parse_phase = a2u_pkg::PH_START;
   logic [31:0]        parse_acc = 32'd0;
   logic               base_detect = 1'b1;
   parse_result_type   expected_results[$];

   logic [7:0] text_buf[$];
   int         send_idle_pct = 0;
   int         stall_pct = 0;
   int         error_count = 0;
   int         results_checked = 0;
   int         chars_sent = 0;
   int         strings_sent = 0;
   int         cycle_count = 0;

   ascii_to_u32_parser dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value     (rsp_value),
      .rsp_error     (rsp_error),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_auto_base (csr_auto_base)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_results.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic void note_mismatch(input string what, input logic [31:0] want,
                                         input logic [31:0] got);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("mismatch in %s: expected %h, got %h", what, want, got);
   endfunction

   function automatic void decimal_digit(input logic [7:0] c);
      if (c >= a2u_pkg::CHAR_ZERO && c <= a2u_pkg::CHAR_NINE &&
          (parse_acc < a2u_pkg::DEC_LIMIT ||
           (parse_acc == a2u_pkg::DEC_LIMIT && c < a2u_pkg::CHAR_SIX))) begin
         parse_acc = parse_acc * 32'd10 + {24'd0, c - a2u_pkg::CHAR_ZERO};
      end else begin
         parse_phase = a2u_pkg::PH_ERR;
      end
   endfunction

   // Advances the predicted parse by one character; a NUL yields one result.
   function automatic void parse_char(input logic [7:0] c);
      parse_result_type res;
      logic [7:0]       up;
      logic [3:0]       nib;
      logic             nib_ok;
      if (c == a2u_pkg::CHAR_NUL) begin
         res.error = (parse_phase == a2u_pkg::PH_ZERO || parse_phase == a2u_pkg::PH_OCT ||
                      parse_phase == a2u_pkg::PH_ERR);
         res.value = (parse_phase == a2u_pkg::PH_ZERO || parse_phase == a2u_pkg::PH_OCT)
                     ? 32'd0 : parse_acc;
         expected_results.push_back(res);
         parse_phase = a2u_pkg::PH_START;
         parse_acc = 32'd0;
      end else begin
         case (parse_phase)
            a2u_pkg::PH_START: begin
               parse_acc = 32'd0;
               if (base_detect && c == a2u_pkg::CHAR_ZERO) begin
                  parse_phase = a2u_pkg::PH_ZERO;
               end else begin
                  parse_phase = a2u_pkg::PH_DEC;
                  decimal_digit(c);
               end
            end
            a2u_pkg::PH_ZERO: begin
               parse_phase = (c == a2u_pkg::CHAR_LO_X || c == a2u_pkg::CHAR_UP_X)
                             ? a2u_pkg::PH_HEX : a2u_pkg::PH_OCT;
            end
            a2u_pkg::PH_DEC: decimal_digit(c);
            a2u_pkg::PH_HEX: begin
               up = (c >= a2u_pkg::CHAR_LO_A && c <= CHAR_LO_Z) ? c - CASE_OFFSET : c;
               nib = 4'd0;
               nib_ok = 1'b1;
               if (up >= a2u_pkg::CHAR_ZERO && up <= a2u_pkg::CHAR_NINE)
                  nib = 4'(up - a2u_pkg::CHAR_ZERO);
               else if (up >= a2u_pkg::CHAR_UP_A && up <= a2u_pkg::CHAR_UP_F)
                  nib = 4'(up - a2u_pkg::CHAR_UP_A + 8'd10);
               else
                  nib_ok = 1'b0;
               if (!nib_ok)
                  parse_phase = a2u_pkg::PH_ERR;
               else if (parse_acc < HEX_LIMIT)
                  parse_acc = {parse_acc[27:0], nib};
               else
                  parse_phase = a2u_pkg::PH_ERR;
            end
            default: ;
         endcase
      end
   endfunction

   always @(posedge clock) begin : check_results
      parse_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            note_mismatch("unexpected result value", 32'd0, rsp_value);
         end else begin
            want = expected_results.pop_front();
            results_checked++;
            if (rsp_value !== want.value)
               note_mismatch("value", want.value, rsp_value);
            if (rsp_error !== want.error)
               note_mismatch("error flag", {31'd0, want.error}, {31'd0, rsp_error});
         end
      end
   end

   // The previous request leaves valid high, so it is only lowered when a gap follows.
   task automatic send_char(input logic [7:0] c);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_code <= c;
      do @(posedge clock); while (req_stall);
      parse_char(c);
      chars_sent++;
      if (c == a2u_pkg::CHAR_NUL)
         strings_sent++;
   endtask

   task automatic send_text();
      foreach (text_buf[i])
         send_char(text_buf[i]);
      send_char(a2u_pkg::CHAR_NUL);
   endtask

   task automatic send_literal(input string s);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i]);
      send_char(a2u_pkg::CHAR_NUL);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_auto_base(input logic b);
      wait_drained();
      csr_valid <= 1'b1;
      csr_auto_base <= b;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      base_detect = b;
   endtask

   task automatic set_idle_mode(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 81;
            stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            stall_pct = 81;
         end
         default: begin
            send_idle_pct = 9;
            stall_pct = 9;
         end
      endcase
   endtask

   task automatic push_decimal(input longint unsigned v);
      int pos;
      pos = text_buf.size();
      do begin
         text_buf.insert(pos, a2u_pkg::CHAR_ZERO + 8'(v % 10));
         v = v / 10;
      end while (v != 0);
   endtask

   task automatic push_hex_digit();
      int d;
      d = $urandom_range(15);
      if (d < 10)
         text_buf.push_back(a2u_pkg::CHAR_ZERO + 8'(d));
      else if ($urandom_range(1) == 1)
         text_buf.push_back(a2u_pkg::CHAR_LO_A + 8'(d - 10));
      else
         text_buf.push_back(a2u_pkg::CHAR_UP_A + 8'(d - 10));
   endtask

   task automatic make_number_text();
      int n;
      longint unsigned v;
      case ($urandom_range(3))
         0, 1: begin
            // Plain decimal; a leading zero now and then turns octal under detection.
            n = $urandom_range(1, 10);
            text_buf.push_back(a2u_pkg::CHAR_ZERO +
                               8'($urandom_range(($urandom_range(4) == 0) ? 0 : 1, 9)));
            for (int i = 1; i < n; i++)
               text_buf.push_back(a2u_pkg::CHAR_ZERO + 8'($urandom_range(9)));
         end
         2: begin
            // Around the top of the 32-bit range, sometimes one digit too long.
            v = 64'd4294967275 + longint'($urandom_range(40));
            if ($urandom_range(3) == 0)
               v = v * 10 + longint'($urandom_range(9));
            push_decimal(v);
         end
         default: begin
            text_buf.push_back(a2u_pkg::CHAR_ZERO);
            text_buf.push_back(($urandom_range(1) == 1) ? a2u_pkg::CHAR_LO_X
                                                         : a2u_pkg::CHAR_UP_X);
            n = ($urandom_range(3) == 0) ? $urandom_range(0, 7) : $urandom_range(8, 9);
            for (int i = 0; i < n; i++)
               push_hex_digit();
         end
      endcase
   endtask

   task automatic make_random_text();
      int pick;
      int n;
      text_buf.delete();
      pick = $urandom_range(99);
      if (pick < 72) begin
         make_number_text();
      end else if (pick < 80) begin
         text_buf.push_back(a2u_pkg::CHAR_ZERO);
         n = $urandom_range(3);
         for (int i = 0; i < n; i++)
            text_buf.push_back(a2u_pkg::CHAR_ZERO + 8'($urandom_range(9)));
      end else if (pick < 90) begin
         make_number_text();
         text_buf.insert($urandom_range(text_buf.size()), 8'($urandom_range(1, 255)));
      end else begin
         n = $urandom_range(6);
         for (int i = 0; i < n; i++)
            text_buf.push_back(8'($urandom_range(1, 255)));
      end
   endtask

   task automatic test_auto_base_specials();
      write_auto_base(1'b1);
      send_char(a2u_pkg::CHAR_NUL);
      send_literal("0");
      send_literal("0x");
      send_literal("0XaF");
      send_literal("9");
      send_literal("a");
      send_char(8'h80);
      send_char(a2u_pkg::CHAR_NUL);
      send_char(a2u_pkg::CHAR_ZERO);
      send_char(8'hFF);
      send_char(a2u_pkg::CHAR_NUL);
   endtask

   task automatic test_decimal_only_specials();
      write_auto_base(1'b0);
      send_literal("0");
      send_literal("0x");
      send_literal("07");
   endtask

   // A run of random strings; halfway through the sender holds off until drained.
   task automatic test_random_strings(input idle_mode_type mode, input logic auto_base,
                                      input int n_chars);
      int  start;
      bit  paused;
      write_auto_base(auto_base);
      set_idle_mode(mode);
      start = chars_sent;
      paused = 1'b0;
      while (chars_sent - start < n_chars) begin
         make_random_text();
         send_text();
         if (!paused && chars_sent - start >= n_chars / 2) begin
            wait_drained();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_auto_base_specials();
      test_decimal_only_specials();
      test_random_strings(IDLE_NONE, 1'b1, 200);
      test_random_strings(IDLE_SENDER, 1'b0, 150);
      test_random_strings(IDLE_RECEIVER, 1'b1, 200);
      test_random_strings(IDLE_BOTH, 1'b0, 150);
      test_random_strings(IDLE_NONE, 1'b0, 75);
      test_random_strings(IDLE_BOTH, 1'b1, 75);
      wait_drained();
      $display("sent %0d characters in %0d strings, checked %0d results", chars_sent,
               strings_sent, results_checked);
      $display("decimal, hex, octal and malformed text, base detection on and off");
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", error_count);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
